>>> rtl/twio_pkg.sv
// ----------------------------------------------------------------------------
// twio_pkg: shared definitions for the two-wheel IMU odometry block
// Constants, register indexes, the CORDIC arctangent table and the status
// type that the trig unit reports to the sequencer.
// ----------------------------------------------------------------------------
package twio_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_FRAC_BITS    = 16;

  // Shared multiplier operand and product widths.
  localparam int MUL_W = 35;
  localparam int ACC_W = 2 * MUL_W;

  // pi*8/1125 * 2^32, turns angle*diameter into Q16.16 inches.
  localparam logic [26:0] DIST_K = 27'd95950490;
  // Centidegrees to radians in Q2.30, scaled by 2^16.
  localparam logic [33:0] CD_TO_RAD = 34'd12281662764;
  // CORDIC gain in Q2.30.
  localparam longint GAIN_Q30 = 652032875;

  localparam int TURN_CD  = 36000;
  localparam int HALF_CD  = 18000;
  localparam int QUART_CD = 9000;

  // Highest shift used by the restoring reduction modulo one turn.
  localparam int MOD_TOP = 18;
  localparam int ATAN_IDX_W = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 2'd2;
  localparam logic [CFG_DATA_W-1:0] DIAMETER_RESET    = 16'd704;

  typedef struct packed {
    logic busy;
    logic done;
  } twio_trig_stat_t;

  function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/twio_in_if.sv
// ----------------------------------------------------------------------------
// twio_in_if: sensor sample channel
// Valid/ready channel carrying one odometry command or sensor sample.
// ----------------------------------------------------------------------------
interface twio_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] x_wheel_angle;
  logic signed [31:0] y_wheel_angle;
  logic signed [31:0] heading_reading;
  logic signed [31:0] set_x;
  logic signed [31:0] set_y;

  modport source (output valid, command, x_wheel_angle, y_wheel_angle, heading_reading,
                  set_x, set_y, input ready);
  modport sink   (input valid, command, x_wheel_angle, y_wheel_angle, heading_reading,
                  set_x, set_y, output ready);
endinterface

>>> rtl/twio_out_if.sv
// ----------------------------------------------------------------------------
// twio_out_if: pose result channel
// Valid/ready channel carrying the field pose after each transfer in.
// ----------------------------------------------------------------------------
interface twio_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

>>> rtl/twio_mul.sv
// ----------------------------------------------------------------------------
// twio_mul: shared signed multiplier
// One registered signed product per cycle, reused by the sequencer.
// ----------------------------------------------------------------------------
module twio_mul (
  input  logic                              clk,
  input  logic signed [twio_pkg::MUL_W-1:0] mul_a,
  input  logic signed [twio_pkg::MUL_W-1:0] mul_b,
  output logic signed [twio_pkg::ACC_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

>>> rtl/twio_trig.sv
// ----------------------------------------------------------------------------
// twio_trig: iterative cosine and sine of a centidegree angle
// Reduces the angle modulo one turn one bit per cycle, folds it into the
// right half plane, converts it to radians and runs one CORDIC step a cycle.
// ----------------------------------------------------------------------------
module twio_trig #(
  parameter int CORDIC_STEPS = twio_pkg::DEF_CORDIC_STEPS,
  parameter int FRAC_BITS    = twio_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [32:0]               angle,
  output twio_pkg::twio_trig_stat_t        stat,
  output logic signed [FRAC_BITS+2:0]      cos_r,
  output logic signed [FRAC_BITS+2:0]      sin_r
);

  localparam int CW = FRAC_BITS + 3;
  localparam int IW = twio_pkg::ATAN_IDX_W;
  localparam longint X0_L = (twio_pkg::GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS)))
                            >> (30 - FRAC_BITS);
  localparam logic signed [CW-1:0] X0 = CW'(X0_L);
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);
  localparam logic signed [17:0] TURN  = 18'(twio_pkg::TURN_CD);
  localparam logic signed [17:0] HALF  = 18'(twio_pkg::HALF_CD);
  localparam logic signed [17:0] QUART = 18'(twio_pkg::QUART_CD);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MOD  = 3'd1;
  localparam logic [2:0] T_FOLD = 3'd2;
  localparam logic [2:0] T_MUL  = 3'd3;
  localparam logic [2:0] T_ZSET = 3'd4;
  localparam logic [2:0] T_ROT  = 3'd5;
  localparam logic [2:0] T_END  = 3'd6;

  logic [2:0]               st_r, st_nxt;
  logic                     neg_r, flip_r, zneg_r;
  logic [33:0]              rem_r;
  logic [4:0]               k_r;
  logic [13:0]              mag_r;
  logic [47:0]              prod_r;
  logic signed [CW-1:0]     x_r, y_r;
  logic signed [33:0]       z_r;
  logic [IW-1:0]            i_r;

  logic signed [33:0]       ang_w;
  logic [33:0]              sub_w;
  logic [15:0]              m_w;
  logic signed [17:0]       r0, r1, r2;
  logic                     fl_w;
  logic [13:0]              fmag_w;
  logic [47:0]              zr_w;
  logic signed [CW-1:0]     xs_w, ys_w;
  logic signed [33:0]       at_w;

  assign stat.busy = (st_r != T_IDLE);
  assign stat.done = (st_r == T_END);

  assign ang_w = 34'(angle);
  assign sub_w = 34'(twio_pkg::TURN_CD) << k_r;

  always_comb begin
    m_w = rem_r[15:0];
    r0  = (neg_r && (m_w != 16'd0)) ? TURN - signed'({2'b00, m_w}) : signed'({2'b00, m_w});
    r1  = (r0 > HALF) ? r0 - TURN : r0;
    if (r1 > QUART) begin
      r2   = r1 - HALF;
      fl_w = 1'b1;
    end else if (r1 < -QUART) begin
      r2   = r1 + HALF;
      fl_w = 1'b1;
    end else begin
      r2   = r1;
      fl_w = 1'b0;
    end
    fmag_w = r2[17] ? 14'(-r2) : 14'(r2);
  end

  assign zr_w = prod_r + 48'd32768;
  assign xs_w = x_r >>> i_r;
  assign ys_w = y_r >>> i_r;
  assign at_w = signed'({4'b0000, twio_pkg::atan_q30(i_r)});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: if (start) st_nxt = T_MOD;
      T_MOD:  if (k_r == 5'd0) st_nxt = T_FOLD;
      T_FOLD: st_nxt = T_MUL;
      T_MUL:  st_nxt = T_ZSET;
      T_ZSET: st_nxt = T_ROT;
      T_ROT:  if (i_r == LAST_STEP) st_nxt = T_END;
      T_END:  st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      T_IDLE: begin
        neg_r <= ang_w[33];
        rem_r <= ang_w[33] ? unsigned'(-ang_w) : unsigned'(ang_w);
        k_r   <= 5'(twio_pkg::MOD_TOP);
      end
      T_MOD: begin
        if (rem_r >= sub_w) rem_r <= rem_r - sub_w;
        k_r <= k_r - 5'd1;
      end
      T_FOLD: begin
        mag_r  <= fmag_w;
        zneg_r <= r2[17];
        flip_r <= fl_w;
      end
      T_MUL: begin
        prod_r <= 48'(mag_r) * 48'(twio_pkg::CD_TO_RAD);
      end
      T_ZSET: begin
        z_r <= zneg_r ? -signed'({2'b00, zr_w[47:16]}) : signed'({2'b00, zr_w[47:16]});
        x_r <= X0;
        y_r <= '0;
        i_r <= '0;
      end
      T_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys_w;
          y_r <= y_r + xs_w;
          z_r <= z_r - at_w;
        end else begin
          x_r <= x_r + ys_w;
          y_r <= y_r - xs_w;
          z_r <= z_r + at_w;
        end
        i_r <= i_r + IW'(1);
      end
      T_END: begin
        cos_r <= flip_r ? -x_r : x_r;
        sin_r <= flip_r ? -y_r : y_r;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/two_wheel_imu_odometry.sv
// ----------------------------------------------------------------------------
// two_wheel_imu_odometry: field pose from two tracking wheels and an IMU
// For a sensor update, the time from the input transfer to a valid pose is
// set by the two passes through the one trig unit; a set-pose command makes
// no trig pass. One item is in work at a time.
// Reset (rst_n, synchronous, active low) clears the pose, the stored
// references and the offsets and loads the default wheel diameter.
// ----------------------------------------------------------------------------
//
// A small sequencer drives one shared multiplier through the distance, arc
// correction and rotation products, while the trig unit computes cosine and
// sine first of the heading change and then of the stored field heading.
// The trig pass on the heading change starts at the input transfer and runs
// alongside the distance products. The finished pose sits in an output
// register, so a new sample can be taken while the result waits for its
// transfer out.
module two_wheel_imu_odometry #(
  parameter int CORDIC_STEPS = twio_pkg::DEF_CORDIC_STEPS,
  parameter int FRAC_BITS    = twio_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  twio_in_if.sink                              in_ch,
  twio_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [twio_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twio_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = FRAC_BITS + 3;
  localparam int MW    = twio_pkg::MUL_W;
  localparam int AW    = twio_pkg::ACC_W;
  localparam int DW    = 34;

  localparam logic signed [CW:0]   ONE    = (CW+1)'(1) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] RND    = AW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AW:0]   SAT_HI = (AW+1)'(2147483647);
  localparam logic signed [AW:0]   SAT_LO = -SAT_HI - (AW+1)'(1);
  localparam logic [AW-1:0]        HALF16 = AW'(32768);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MXA  = 5'd1;
  localparam logic [4:0] S_MYA  = 5'd2;
  localparam logic [4:0] S_MXH  = 5'd3;
  localparam logic [4:0] S_MXL  = 5'd4;
  localparam logic [4:0] S_MYH  = 5'd5;
  localparam logic [4:0] S_MYL  = 5'd6;
  localparam logic [4:0] S_DY   = 5'd7;
  localparam logic [4:0] S_WT1  = 5'd8;
  localparam logic [4:0] S_C1   = 5'd9;
  localparam logic [4:0] S_C2   = 5'd10;
  localparam logic [4:0] S_C3   = 5'd11;
  localparam logic [4:0] S_C4   = 5'd12;
  localparam logic [4:0] S_C5   = 5'd13;
  localparam logic [4:0] S_DYC  = 5'd14;
  localparam logic [4:0] S_WT2  = 5'd15;
  localparam logic [4:0] S_G1   = 5'd16;
  localparam logic [4:0] S_G2   = 5'd17;
  localparam logic [4:0] S_G3   = 5'd18;
  localparam logic [4:0] S_G4   = 5'd19;
  localparam logic [4:0] S_G5   = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;

  logic [4:0] state_r, state_nxt;

  // Configuration registers.
  logic [15:0]        diam_r;
  logic signed [15:0] ox_r, oy_r;

  // Persistent odometry state.
  logic [31:0]        last_xd_r, last_yd_r;
  logic signed [31:0] last_hd_r, fx_r, fy_r, fh_r;

  // Captured input sample.
  logic               cmd_r;
  logic signed [31:0] xa_r, ya_r, hd_r, sx_r, sy_r;

  // Working registers.
  logic [47:0]        magx_r, magy_r;
  logic               negx_r, negy_r;
  logic signed [AW-1:0] acc_r;
  logic [31:0]        xdn_r, ydn_r;
  logic signed [CW-1:0] dc_r, ds_r;
  logic signed [DW-1:0] cx_r, cy_r, dx_r, dy_r;
  logic signed [31:0] nfx_r, nfy_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] pose_x_r, pose_y_r, pose_h_r;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] prod;

  // Trig unit.
  logic                      trig_start;
  logic signed [32:0]        trig_angle;
  twio_pkg::twio_trig_stat_t trig_stat;
  logic signed [CW-1:0]      trig_cos, trig_sin;

  logic               in_xfer, commit;
  logic signed [32:0] hdelta;
  logic signed [CW:0] dcm1;
  logic signed [AW-1:0] pmag;
  logic [AW-1:0]      dsum;
  logic [31:0]        dist_w;
  logic signed [31:0] wdx, wdy;

  function automatic logic signed [AW-1:0] rshift(input logic signed [AW-1:0] v);
    return (v + RND) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7fffffff;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  twio_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  twio_trig #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (trig_angle),
    .stat  (trig_stat),
    .cos_r (trig_cos),
    .sin_r (trig_sin)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_xfer          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pose_x    = pose_x_r;
  assign out_ch.pose_y    = pose_y_r;
  assign out_ch.pose_heading = pose_h_r;

  // The heading change is exact in 33 bits; the trig unit reduces it.
  assign hdelta = 33'(in_ch.heading_reading) - 33'(last_hd_r);

  // First trig pass starts with the input transfer of a sensor update, the
  // second as soon as the first has handed over its results.
  assign trig_start = (in_xfer && !in_ch.command) ||
                      ((state_r == S_WT1) && !trig_stat.busy);
  assign trig_angle = (state_r == S_IDLE) ? hdelta : 33'(fh_r);

  assign dcm1 = (CW+1)'(dc_r) - ONE;

  // Multiplier operand selection: each state that multiplies issues one
  // product, which the following state consumes from the product register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MXA: begin mul_a = MW'(xa_r);  mul_b = MW'(diam_r); end
      S_MYA: begin mul_a = MW'(ya_r);  mul_b = MW'(diam_r); end
      S_MXH: begin mul_a = MW'(magx_r[47:16]); mul_b = MW'(twio_pkg::DIST_K); end
      S_MXL: begin mul_a = MW'(magx_r[15:0]);  mul_b = MW'(twio_pkg::DIST_K); end
      S_MYH: begin mul_a = MW'(magy_r[47:16]); mul_b = MW'(twio_pkg::DIST_K); end
      S_MYL: begin mul_a = MW'(magy_r[15:0]);  mul_b = MW'(twio_pkg::DIST_K); end
      S_C1:  begin mul_a = MW'(ox_r);  mul_b = MW'(dcm1); end
      S_C2:  begin mul_a = MW'(oy_r);  mul_b = MW'(ds_r); end
      S_C3:  begin mul_a = MW'(ox_r);  mul_b = MW'(ds_r); end
      S_C4:  begin mul_a = MW'(oy_r);  mul_b = MW'(dcm1); end
      S_G1:  begin mul_a = MW'(dx_r);  mul_b = MW'(trig_cos); end
      S_G2:  begin mul_a = MW'(dy_r);  mul_b = MW'(trig_sin); end
      S_G3:  begin mul_a = MW'(dx_r);  mul_b = MW'(trig_sin); end
      S_G4:  begin mul_a = MW'(dy_r);  mul_b = MW'(trig_cos); end
      default: ;
    endcase
  end

  // Magnitude of a wheel product and the rounded Q16.16 distance built from
  // the high and low partial products.
  assign pmag = prod[AW-1] ? -prod : prod;
  assign dsum = unsigned'(acc_r) + (unsigned'(prod + signed'(HALF16)) >> 16) + HALF16;

  always_comb begin
    logic neg;
    neg = (state_r == S_MYH) ? negx_r : negy_r;
    dist_w = neg ? 32'd0 - dsum[47:16] : dsum[47:16];
  end

  // Wheel deltas wrap modulo 2^32.
  assign wdx = signed'(xdn_r - last_xd_r);
  assign wdy = signed'(ydn_r - last_yd_r);

  assign commit = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_MXA;
      S_MXA:  state_nxt = S_MYA;
      S_MYA:  state_nxt = S_MXH;
      S_MXH:  state_nxt = S_MXL;
      S_MXL:  state_nxt = S_MYH;
      S_MYH:  state_nxt = S_MYL;
      S_MYL:  state_nxt = S_DY;
      S_DY:   state_nxt = cmd_r ? S_DONE : S_WT1;
      S_WT1:  if (!trig_stat.busy) state_nxt = S_C1;
      S_C1:   state_nxt = S_C2;
      S_C2:   state_nxt = S_C3;
      S_C3:   state_nxt = S_C4;
      S_C4:   state_nxt = S_C5;
      S_C5:   state_nxt = S_DYC;
      S_DYC:  state_nxt = S_WT2;
      S_WT2:  if (!trig_stat.busy) state_nxt = S_G1;
      S_G1:   state_nxt = S_G2;
      S_G2:   state_nxt = S_G3;
      S_G3:   state_nxt = S_G4;
      S_G4:   state_nxt = S_G5;
      S_G5:   state_nxt = S_DONE;
      S_DONE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // Control, configuration and odometry state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      diam_r      <= twio_pkg::DIAMETER_RESET;
      ox_r        <= '0;
      oy_r        <= '0;
      last_xd_r   <= '0;
      last_yd_r   <= '0;
      last_hd_r   <= '0;
      fx_r        <= '0;
      fy_r        <= '0;
      fh_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          twio_pkg::REG_WHEEL_DIAMETER: diam_r <= cfg_data;
          twio_pkg::REG_OFFSET_X:       ox_r   <= signed'(cfg_data);
          twio_pkg::REG_OFFSET_Y:       oy_r   <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (commit) begin
        // A set-pose command loads the pose as given and adds no motion.
        fx_r      <= cmd_r ? sx_r : nfx_r;
        fy_r      <= cmd_r ? sy_r : nfy_r;
        fh_r      <= hd_r;
        last_hd_r <= hd_r;
        last_xd_r <= xdn_r;
        last_yd_r <= ydn_r;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (commit) begin
      pose_x_r <= cmd_r ? sx_r : nfx_r;
      pose_y_r <= cmd_r ? sy_r : nfy_r;
      pose_h_r <= hd_r;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_r <= in_ch.command;
          xa_r  <= in_ch.x_wheel_angle;
          ya_r  <= in_ch.y_wheel_angle;
          hd_r  <= in_ch.heading_reading;
          sx_r  <= in_ch.set_x;
          sy_r  <= in_ch.set_y;
        end
      end
      S_MYA: begin
        magx_r <= pmag[47:0];
        negx_r <= prod[AW-1];
      end
      S_MXH: begin
        magy_r <= pmag[47:0];
        negy_r <= prod[AW-1];
      end
      S_MXL: acc_r <= prod;
      S_MYH: xdn_r <= dist_w;
      S_MYL: acc_r <= prod;
      S_DY:  ydn_r <= dist_w;
      S_WT1: begin
        dc_r <= trig_cos;
        ds_r <= trig_sin;
      end
      S_C2:  acc_r <= prod;
      // Arc terms are scaled from 1/256 inch to Q16.16 before rounding.
      S_C3:  cx_r  <= DW'(rshift((acc_r - prod) <<< 8));
      S_C4:  acc_r <= prod;
      S_C5: begin
        cy_r <= DW'(rshift((acc_r + prod) <<< 8));
        dx_r <= DW'(wdx) - cx_r;
      end
      S_DYC: dy_r <= DW'(wdy) - cy_r;
      S_G2:  acc_r <= prod;
      S_G3:  nfx_r <= sat32((AW+1)'(fx_r) + (AW+1)'(rshift(acc_r - prod)));
      S_G4:  acc_r <= prod;
      S_G5:  nfy_r <= sat32((AW+1)'(fy_r) + (AW+1)'(rshift(acc_r + prod)));
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // The trig unit is always finished before the block takes a new sample.
  a_idle_trig: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !trig_stat.busy)
    else $error("trig unit busy while sequencer idle");

  // A trig pass is never started on top of another one.
  a_trig_start: assert property (@(posedge clk) disable iff (!rst_n)
    trig_start |-> !trig_stat.busy)
    else $error("trig start while busy");

  // The trig unit returns to idle right after reporting done.
  a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
    trig_stat.done |=> !trig_stat.busy)
    else $error("trig unit stays busy after done");

  // A result only appears from the final sequencer state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid without a finished item");
`endif

endmodule
